### rtl/core/rgb_to_yuv_format_packer_top_macros.svh
// Assertion macros for the RGB to YUV format packer.
// Included by the top level; no other dependencies.
`ifndef RGB_TO_YUV_FORMAT_PACKER_TOP_MACROS_SVH
`define RGB_TO_YUV_FORMAT_PACKER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a condition holds at every clock edge outside reset
`define RTYFP_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rtyfp assertion failed");

// Check that a trigger implies a consequence in the same cycle
`define RTYFP_ASSERT_IMP(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("rtyfp implication failed");

`else

`define RTYFP_ASSERT(lbl, clk, rst_n, cond)
`define RTYFP_ASSERT_IMP(lbl, clk, rst_n, trig, cons)

`endif

`endif

### rtl/core/rtyfp_pkg.sv
// Shared types, constants and color math for the RGB to YUV format packer.
// Used by every module of the block; depends on nothing.
package rtyfp_pkg;

    // Frame geometry
    localparam int MAX_DIM  = 8192;
    localparam int CNT_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = CNT_W + 1;
    localparam int DIMREG_W = 14;
    localparam int PITCH_W  = 16;

    // Result field widths
    localparam int ADDR_W  = 33;
    localparam int WORD_W  = 32;
    localparam int BCNT_W  = 3;
    localparam int TDATA_W = 104;
    localparam int SUM_W   = 26;

    // Intermediate widths
    localparam int ROWOFS_W = CNT_W + PITCH_W;
    localparam int COLOFS_W = CNT_W + 3;
    localparam int ROWS_W   = DIM_W + 1;
    localparam int TOT_W    = ROWS_W + PITCH_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE1  = 3'd5;

    // Output format codes
    localparam logic [3:0] FMT_NV12   = 4'd0;
    localparam logic [3:0] FMT_YUYV   = 4'd1;
    localparam logic [3:0] FMT_BGR    = 4'd2;
    localparam logic [3:0] FMT_YUV444 = 4'd3;
    localparam logic [3:0] FMT_GRAY   = 4'd4;
    localparam logic [3:0] FMT_ABGR   = 4'd6;

    // BT.601 full-range coefficients, 16-bit fraction
    localparam int C_Y_R    = 19595;
    localparam int C_Y_G    = 38470;
    localparam int C_Y_B    = 7471;
    localparam int C_HALF   = 32768;
    localparam int C_CB_R   = -11059;
    localparam int C_CB_G   = -21709;
    localparam int C_CR_G   = -27439;
    localparam int C_CR_B   = -5329;
    localparam int C_C_OFS  = 8388608;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic [3:0]          fmt;
        logic [2:0]          bpp;
        logic [PITCH_W-1:0]  pitch;
        logic [WORD_W-1:0]   base0;
        logic [WORD_W-1:0]   base1;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
        logic             last;
        logic             chroma;
    } t_pix1;

    typedef struct packed {
        logic [7:0]              red;
        logic [7:0]              green;
        logic [7:0]              blue;
        logic [CNT_W-1:0]        col;
        logic [ROWOFS_W-1:0]     rowofs;
        logic [COLOFS_W-1:0]     colofs;
        logic signed [SUM_W-1:0] ysum;
        logic signed [SUM_W-1:0] cbsum;
        logic signed [SUM_W-1:0] crsum;
        logic [WORD_W-1:0]       total;
        logic                    last;
        logic                    chroma;
    } t_pix2;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] data_word;
        logic [BCNT_W-1:0] byte_count;
        logic              pixel_last;
        logic              frame_last;
        logic [WORD_W-1:0] total_bytes;
    } t_result;

    typedef struct packed {
        t_result    first;
        t_result    second;
        logic [1:0] n;
    } t_pair;

    // Bytes per pixel of a format, zero for an unknown code
    function automatic logic [2:0] fmt_bpp(logic [3:0] fmt);
        logic [2:0] bpp;
        unique case (fmt)
            FMT_NV12:   bpp = 3'd1;
            FMT_YUYV:   bpp = 3'd2;
            FMT_BGR:    bpp = 3'd3;
            FMT_YUV444: bpp = 3'd3;
            FMT_GRAY:   bpp = 3'd1;
            FMT_ABGR:   bpp = 3'd4;
            default:    bpp = 3'd0;
        endcase
        return bpp;
    endfunction

    // Zero counts as one, oversize saturates
    function automatic logic [DIM_W-1:0] eff_dim(logic [DIMREG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (v > DIMREG_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    function automatic logic signed [SUM_W-1:0] luma_sum(logic [7:0] r, logic [7:0] g,
                                                        logic [7:0] b);
        int s;
        s = C_Y_R * int'(r) + C_Y_G * int'(g) + C_Y_B * int'(b) + C_HALF;
        return SUM_W'(s);
    endfunction

    function automatic logic signed [SUM_W-1:0] cb_sum(logic [7:0] r, logic [7:0] g,
                                                      logic [7:0] b);
        int s;
        s = C_CB_R * int'(r) + C_CB_G * int'(g) + C_HALF * int'(b) + C_C_OFS;
        return SUM_W'(s);
    endfunction

    function automatic logic signed [SUM_W-1:0] cr_sum(logic [7:0] r, logic [7:0] g,
                                                      logic [7:0] b);
        int s;
        s = C_HALF * int'(r) + C_CR_G * int'(g) + C_CR_B * int'(b) + C_C_OFS;
        return SUM_W'(s);
    endfunction

    // Drop the fraction and clamp to a byte
    function automatic logic [7:0] sat_u8(logic signed [SUM_W-1:0] s);
        logic [SUM_W-17:0] q;
        logic [7:0]        v;
        q = s[SUM_W-1:16];
        if (s < 0) begin
            v = 8'd0;
        end else if (q > (SUM_W-16)'(255)) begin
            v = 8'd255;
        end else begin
            v = q[7:0];
        end
        return v;
    endfunction

endpackage

### rtl/core/rtyfp_position.sv
// Input stage: tracks the raster position and registers each accepted pixel.
// Depends on rtyfp_pkg.
module rtyfp_position
    import rtyfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_ready,
    output t_pix1      o_pix
);

    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [CNT_W-1:0] cur_col, cur_row;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             accept;
    logic             r_valid;
    t_pix1            r_pix, n_pix;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Wrap a position left beyond a shrunken frame, then find the next one
    always_comb begin
        cur_col = ({1'b0, r_col} >= i_cfg.width)  ? '0 : r_col;
        cur_row = ({1'b0, r_row} >= i_cfg.height) ? '0 : r_row;
        col_inc = {1'b0, cur_col} + DIM_W'(1);
        row_inc = {1'b0, cur_row} + DIM_W'(1);

        n_pix.red    = i_red;
        n_pix.green  = i_green;
        n_pix.blue   = i_blue;
        n_pix.col    = cur_col;
        n_pix.row    = cur_row;
        n_pix.last   = (col_inc == i_cfg.width) && (row_inc == i_cfg.height);
        n_pix.chroma = (i_cfg.fmt == FMT_NV12) && !cur_row[0] && !cur_col[0] &&
                       (row_inc < i_cfg.height) && (col_inc < i_cfg.width);

        priority if (n_pix.last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= i_cfg.width) begin
            n_col = '0;
            n_row = row_inc[CNT_W-1:0];
        end else begin
            n_col = col_inc[CNT_W-1:0];
            n_row = cur_row;
        end
    end

    // Advance the position and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    // Hold the pixel
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

### rtl/core/rtyfp_convert.sv
// Math stage: color sums and address offsets, then clamp, pack and add bases.
// Depends on rtyfp_pkg.
module rtyfp_convert
    import rtyfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_pix1 i_pix,
    output logic  o_valid,
    input  logic  i_ready,
    output t_pair o_pair
);

    logic              r_valid;
    t_pix2             r_pix2, n_pix2;
    logic [ROWS_W-1:0] rows;
    logic [7:0]        y, cb, cr;
    logic [WORD_W-1:0] data0;

    assign o_ready = !r_valid || i_ready;

    // Products: row offset, column offset, frame size and color sums
    always_comb begin
        rows = (i_cfg.fmt == FMT_NV12) ?
               ROWS_W'(i_cfg.height) + ROWS_W'(i_cfg.height >> 1) :
               ROWS_W'(i_cfg.height);

        n_pix2.red    = i_pix.red;
        n_pix2.green  = i_pix.green;
        n_pix2.blue   = i_pix.blue;
        n_pix2.col    = i_pix.col;
        n_pix2.rowofs = ROWOFS_W'(i_pix.row) * ROWOFS_W'(i_cfg.pitch);
        n_pix2.colofs = COLOFS_W'(i_pix.col) * COLOFS_W'(i_cfg.bpp);
        n_pix2.ysum   = luma_sum(i_pix.red, i_pix.green, i_pix.blue);
        n_pix2.cbsum  = cb_sum(i_pix.red, i_pix.green, i_pix.blue);
        n_pix2.crsum  = cr_sum(i_pix.red, i_pix.green, i_pix.blue);
        n_pix2.total  = WORD_W'(TOT_W'(rows) * TOT_W'(i_cfg.pitch));
        n_pix2.last   = i_pix.last;
        n_pix2.chroma = i_pix.chroma;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pix2 <= n_pix2;
        end
    end

    // Clamp and pack the bytes of the main result
    always_comb begin
        y  = sat_u8(r_pix2.ysum);
        cb = sat_u8(r_pix2.cbsum);
        cr = sat_u8(r_pix2.crsum);
        unique case (i_cfg.fmt)
            FMT_YUYV:   data0 = {16'd0, (r_pix2.col[0] ? cr : cb), y};
            FMT_BGR:    data0 = {8'd0, r_pix2.red, r_pix2.green, r_pix2.blue};
            FMT_YUV444: data0 = {8'd0, cr, cb, y};
            FMT_ABGR:   data0 = {r_pix2.red, r_pix2.green, r_pix2.blue, ALPHA_OPAQUE};
            default:    data0 = {24'd0, y};
        endcase
    end

    // Build the result pair
    always_comb begin
        o_pair.first.address     = ADDR_W'(i_cfg.base0) + ADDR_W'(r_pix2.rowofs) +
                                   ADDR_W'(r_pix2.colofs);
        o_pair.first.data_word   = data0;
        o_pair.first.byte_count  = i_cfg.bpp;
        o_pair.first.pixel_last  = !r_pix2.chroma;
        o_pair.first.frame_last  = r_pix2.last && !r_pix2.chroma;
        o_pair.first.total_bytes = (r_pix2.last && !r_pix2.chroma) ? r_pix2.total : '0;

        // Chroma row offset is half the luma one, the row being even
        o_pair.second.address     = ADDR_W'(i_cfg.base1) + ADDR_W'(r_pix2.rowofs >> 1) +
                                    ADDR_W'(r_pix2.col);
        o_pair.second.data_word   = {16'd0, cr, cb};
        o_pair.second.byte_count  = BCNT_W'(2);
        o_pair.second.pixel_last  = 1'b1;
        o_pair.second.frame_last  = r_pix2.last;
        o_pair.second.total_bytes = r_pix2.last ? r_pix2.total : '0;

        if (i_cfg.bpp == 3'd0) begin
            o_pair.n = 2'd0;
        end else if (r_pix2.chroma) begin
            o_pair.n = 2'd2;
        end else begin
            o_pair.n = 2'd1;
        end
    end

    assign o_valid = r_valid;

endmodule

### rtl/core/rtyfp_out_queue.sv
// Result buffer for up to two results of one pixel, followed by the output register.
// Depends on rtyfp_pkg.
module rtyfp_out_queue
    import rtyfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_pair   i_pair,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic [1:0] r_cnt;
    logic       r_out_valid;
    t_result    r_first, r_second, r_out;
    logic       load, take;

    // Move one result into the output register whenever it frees up
    assign load    = (r_cnt != 2'd0) && (!r_out_valid || i_ready);
    assign o_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && load);
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_cnt <= i_pair.n;
            end else if (load) begin
                r_cnt <= r_cnt - 2'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Shift the second result forward as the first one leaves
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_first  <= i_pair.first;
            r_second <= i_pair.second;
        end else if (load) begin
            r_first <= r_second;
        end
        if (load) begin
            r_out <= r_first;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

### rtl/core/rgb_to_yuv_format_packer_top.sv
// Top level of the RGB to YUV format packer: configuration registers and stages.
// Depends on rtyfp_pkg, rtyfp_position, rtyfp_convert, rtyfp_out_queue and the macros.
//
// Usage:
//   Pixels enter in raster order on the s_axis channel, one RGB item per beat.
//   Each pixel yields one write item on m_axis (address, data bytes, byte count),
//   and an NV12 pixel on an even row and even column, neither the last, yields a
//   second item that carries its Cb,Cr pair for the chroma plane. An unknown
//   format yields none. tuser marks the last item of a pixel, tlast the last item
//   of the frame, which also carries the frame size in bytes.
//   A result passes the input register, the math register, the result buffer
//   and the output register on its way to m_axis. Throughput: one pixel per cycle
//   while m_axis does not stall; a pixel with a chroma pair holds the two-entry
//   result buffer until both items have left it. A stalled receiver holds the
//   output register; buffer, math and input stages then fill; s_axis_tready drops.
//   Reset clears the raster position, all stage valids and the registers to
//   NV12, a 1x1 frame, packed pitch and zero bases.
//   Write registers through i_cfg_we only while no pixel is in flight.
`include "rgb_to_yuv_format_packer_top_macros.svh"

module rgb_to_yuv_format_packer_top
    import rtyfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // pixel input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    // write item output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // address[32:0], data_word[64:33], byte_count[67:65], total_bytes[99:68], zeros
    output logic [TDATA_W-1:0]    m_axis_tdata,
    output logic                  m_axis_tlast,   // frame_last
    output logic                  m_axis_tuser    // pixel_last
);

    logic [3:0]          r_fmt;
    logic [DIMREG_W-1:0] r_width, r_height;
    logic [PITCH_W-1:0]  r_pitch;
    logic [WORD_W-1:0]   r_base0, r_base1;
    t_cfg                cfg;

    logic    pos_valid, pos_ready, cvt_valid, cvt_ready;
    t_pix1   pos_pix;
    t_pair   cvt_pair;
    t_result res;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_NV12;
            r_width  <= DIMREG_W'(1);
            r_height <= DIMREG_W'(1);
            r_pitch  <= '0;
            r_base0  <= '0;
            r_base1  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FORMAT: r_fmt    <= i_cfg_wdata[3:0];
                REG_WIDTH:  r_width  <= i_cfg_wdata[DIMREG_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_wdata[DIMREG_W-1:0];
                REG_PITCH:  r_pitch  <= i_cfg_wdata[PITCH_W-1:0];
                REG_BASE0:  r_base0  <= i_cfg_wdata;
                REG_BASE1:  r_base1  <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Effective geometry; zero pitch means a packed line
    always_comb begin
        cfg.fmt    = r_fmt;
        cfg.bpp    = fmt_bpp(r_fmt);
        cfg.width  = eff_dim(r_width);
        cfg.height = eff_dim(r_height);
        cfg.base0  = r_base0;
        cfg.base1  = r_base1;
        cfg.pitch  = (r_pitch != '0) ? r_pitch :
                     PITCH_W'((DIM_W + 3)'(cfg.width) * (DIM_W + 3)'(cfg.bpp));
    end

    rtyfp_position u_position (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_valid (pos_valid),
        .i_ready (pos_ready),
        .o_pix   (pos_pix)
    );

    rtyfp_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (pos_valid),
        .o_ready (pos_ready),
        .i_pix   (pos_pix),
        .o_valid (cvt_valid),
        .i_ready (cvt_ready),
        .o_pair  (cvt_pair)
    );

    rtyfp_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cvt_valid),
        .o_ready (cvt_ready),
        .i_pair  (cvt_pair),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    // Pack the result item
    assign m_axis_tdata = {4'd0, res.total_bytes, res.byte_count, res.data_word,
                           res.address};
    assign m_axis_tlast = res.frame_last;
    assign m_axis_tuser = res.pixel_last;

    // The frame's last item is always the last item of its pixel
    `RTYFP_ASSERT_IMP(a_frame_last_ends_pixel, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    // Frame size travels only with the frame's last item
    `RTYFP_ASSERT_IMP(a_total_only_at_end, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tlast, m_axis_tdata[99:68] == 32'd0)
    // Every item carries one to four bytes
    `RTYFP_ASSERT_IMP(a_byte_count_range, i_clk, i_rst_n,
        m_axis_tvalid, (m_axis_tdata[67:65] != 3'd0) && (m_axis_tdata[67:65] <= 3'd4))

endmodule
